@@ sv/sbc_pkg.sv @@
`timescale 1ns / 1ps
package sbc_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    localparam int P_W         = T_FRAC_BITS + 35;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = 384;
    localparam int M_DATA_W = 104;

    localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC_BITS;
    localparam logic [T_W-1:0] T_ZERO = '0;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] SIGN_NONE = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    // Classified query: per-axis flags, the start point, the numerator and denominator magnitudes of the
    // two slab divisions, and the signed segment direction.
    typedef struct packed {
        logic [2:0]        reject;
        logic [2:0]        use_min;
        logic [2:0]        use_max;
        logic [2:0]        dec;
        logic [2:0][31:0]  start;
        logic [2:0][32:0]  rel;
        logic [2:0][32:0]  nmin;
        logic [2:0][32:0]  nmax;
        logic [2:0][32:0]  den;
    } cls_item_t;

    // Six division lanes: lane 2*axis is the entry division, 2*axis+1 the exit division.
    typedef struct packed {
        logic [5:0][32:0]            rem;
        logic [5:0][T_FRAC_BITS-1:0] quo;
        logic [5:0]                  sat;
    } div_lanes_t;

endpackage

@@ sv/sbc_front.sv @@
`timescale 1ns / 1ps
module sbc_front import sbc_pkg::*; (
    input  logic [S_DATA_W-1:0] s_tdata,
    output cls_item_t           item
);

    always_comb begin
        logic signed [33:0] s;
        logic signed [33:0] e;
        logic signed [33:0] b;
        logic signed [33:0] m;
        logic signed [33:0] len;
        logic signed [33:0] d_min;
        logic signed [33:0] d_max;
        logic signed [33:0] d_den;
        item = '0;
        for (int i = 0; i < 3; i++) begin
            s   = {{2{s_tdata[i*32+31]}}, s_tdata[i*32 +: 32]};
            e   = {{2{s_tdata[96+i*32+31]}}, s_tdata[96+i*32 +: 32]};
            b   = {{2{s_tdata[192+i*32+31]}}, s_tdata[192+i*32 +: 32]};
            m   = b + $signed({3'b000, s_tdata[288+i*31 +: 31]});
            len = e - s;
            item.start[i] = s[31:0];
            item.rel[i]   = len[32:0];
            if (s < e) begin
                item.dec[i]     = 1'b0;
                item.reject[i]  = (s > m) || (e < b);
                item.use_min[i] = (s < b);
                item.use_max[i] = (e > m);
                d_min = b - s;
                d_max = m - s;
                d_den = e - s;
            end else begin
                // A zero-length axis never divides; it only passes or rejects.
                item.dec[i]     = 1'b1;
                item.reject[i]  = (e > m) || (s < b);
                item.use_min[i] = (s > m) && (len != 0);
                item.use_max[i] = (e < b) && (len != 0);
                d_min = s - m;
                d_max = s - b;
                d_den = s - e;
            end
            item.nmin[i] = d_min[32:0];
            item.nmax[i] = d_max[32:0];
            item.den[i]  = d_den[32:0];
        end
    end

endmodule

@@ sv/sbc_queue.sv @@
`timescale 1ns / 1ps
module sbc_queue import sbc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cls_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output cls_item_t out_item
);

    cls_item_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ sv/sbc_back.sv @@
`timescale 1ns / 1ps
module sbc_back import sbc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  cls_item_t           q_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // clip_x, clip_y, clip_z, normal_axis, normal_sign
    output logic                m_tuser   // hit
);

    // One restoring step on every lane: one quotient bit per stage.
    function automatic div_lanes_t div_step(div_lanes_t l, cls_item_t it);
        div_lanes_t r;
        logic [33:0] r2;
        logic [33:0] dd;
        logic        ge;
        r = l;
        for (int k = 0; k < 6; k++) begin
            dd = {1'b0, it.den[k/2]};
            r2 = {l.rem[k], 1'b0};
            ge = (r2 >= dd);
            r.rem[k] = ge ? 33'(r2 - dd) : r2[32:0];
            r.quo[k] = {l.quo[k][T_FRAC_BITS-2:0], ge};
        end
        return r;
    endfunction

    logic adv;

    logic [T_FRAC_BITS:0] vld_reg;
    cls_item_t            itm_reg  [T_FRAC_BITS+1];
    div_lanes_t           lane_reg [T_FRAC_BITS+1];
    div_lanes_t           lane_init;

    logic                 f_vld_reg, f_miss_reg, f_miss_next;
    logic [T_W-1:0]       f_tmin_reg, f_tmin_next;
    logic [1:0]           f_axis_reg, f_axis_next, f_sign_reg, f_sign_next;
    logic [2:0][31:0]     f_start_reg;
    logic [2:0][32:0]     f_rel_reg;

    logic                 p_vld_reg, p_miss_reg;
    logic [1:0]           p_axis_reg, p_sign_reg;
    logic [2:0][31:0]     p_start_reg;
    logic signed [P_W-1:0] p_prod_reg [3];

    logic                 m_tvalid_reg, m_hit_reg;
    logic [2:0][31:0]     m_clip_reg;
    logic [1:0]           m_axis_reg, m_sign_reg;

    // The whole back end moves as one pipeline whenever the output register can take data.
    assign adv     = !m_tvalid_reg || m_tready;
    assign q_ready = adv;

    always_comb begin
        lane_init = '0;
        for (int k = 0; k < 6; k++) begin
            lane_init.rem[k] = (k % 2 == 0) ? q_item.nmin[k/2] : q_item.nmax[k/2];
            lane_init.sat[k] = (lane_init.rem[k] >= q_item.den[k/2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            itm_reg[0]  <= q_item;
            lane_reg[0] <= lane_init;
        end
    end

    for (genvar g = 1; g <= T_FRAC_BITS; g++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (adv) begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                itm_reg[g]  <= itm_reg[g-1];
                lane_reg[g] <= div_step(lane_reg[g-1], itm_reg[g-1]);
            end
        end
    end

    // Fold the three slabs into the running interval in axis order.
    always_comb begin
        logic [T_W-1:0] tmax;
        logic [T_W-1:0] q;
        logic [T_W-1:0] cmin;
        logic [T_W-1:0] cmax;
        cls_item_t      it;
        div_lanes_t     ln;
        it          = itm_reg[T_FRAC_BITS];
        ln          = lane_reg[T_FRAC_BITS];
        f_tmin_next = T_ZERO;
        tmax        = T_ONE;
        f_axis_next = AXIS_X;
        f_sign_next = SIGN_NONE;
        f_miss_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q    = ln.sat[2*i] ? T_ONE : {1'b0, ln.quo[2*i]};
            cmin = it.use_min[i] ? q : T_ZERO;
            q    = ln.sat[2*i+1] ? T_ONE : {1'b0, ln.quo[2*i+1]};
            cmax = it.use_max[i] ? q : T_ONE;
            if (it.reject[i]) begin
                f_miss_next = 1'b1;
            end
            // An equal entry keeps the earlier axis.
            if (cmin > f_tmin_next) begin
                f_tmin_next = cmin;
                f_axis_next = 2'(i);
                f_sign_next = it.dec[i] ? SIGN_POS : SIGN_NEG;
            end
            if (cmax < tmax) begin
                tmax = cmax;
            end
            if (tmax < f_tmin_next) begin
                f_miss_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg    <= 1'b0;
            p_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            f_vld_reg    <= vld_reg[T_FRAC_BITS];
            p_vld_reg    <= f_vld_reg;
            m_tvalid_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_miss_reg  <= f_miss_next;
            f_tmin_reg  <= f_tmin_next;
            f_axis_reg  <= f_axis_next;
            f_sign_reg  <= f_sign_next;
            f_start_reg <= itm_reg[T_FRAC_BITS].start;
            f_rel_reg   <= itm_reg[T_FRAC_BITS].rel;

            p_miss_reg  <= f_miss_reg;
            p_axis_reg  <= f_axis_reg;
            p_sign_reg  <= f_sign_reg;
            p_start_reg <= f_start_reg;
            for (int i = 0; i < 3; i++) begin
                p_prod_reg[i] <= $signed(f_rel_reg[i]) * $signed({1'b0, f_tmin_reg});
            end

            // An arithmetic shift of the product rounds toward minus infinity.
            m_hit_reg <= !p_miss_reg;
            for (int i = 0; i < 3; i++) begin
                m_clip_reg[i] <= p_miss_reg ? 32'd0
                               : p_start_reg[i] + p_prod_reg[i][T_FRAC_BITS+31:T_FRAC_BITS];
            end
            m_axis_reg <= p_miss_reg ? AXIS_X : p_axis_reg;
            m_sign_reg <= p_miss_reg ? SIGN_NONE : p_sign_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {4'b0000, m_sign_reg, m_axis_reg,
                       m_clip_reg[2], m_clip_reg[1], m_clip_reg[0]};

endmodule

@@ sv/segment_box_clip.sv @@
`timescale 1ns / 1ps
// Segment against axis-aligned box clipper, slab test over x, y and z.
// Input channel s_*: one query per transfer, tdata packs the start point,
// end point, box minimum corner and box extent (Q16.16).
// Output channel m_*: one result per query, in order; tuser is the hit flag
// and tdata holds the entry point, the entry face axis and its sign.
// A front stage classifies each query and writes it into a four-entry queue;
// the back pipeline divides with one quotient bit per stage, folds the
// three slabs, multiplies out the entry point and registers the result.
// From an input transfer to its output a query passes the queue, the divider
// stages, the fold register, the product register and the output register.
// Throughput: one query per cycle while the receiver takes results.
// With m_tvalid high and m_tready low the whole back pipeline holds; the queue
// keeps taking input until its four entries are full, then s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and the pipeline;
// no state carries between queries.
module segment_box_clip import sbc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z,
    // box_min_x, box_min_y, box_min_z, box_extent_x, box_extent_y, box_extent_z
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // clip_x, clip_y, clip_z, normal_axis, normal_sign
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser   // hit
);

    cls_item_t front_item;
    cls_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    sbc_front u_front (
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    sbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result carries nonzero fields");

    a_inside_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[99:98] == SIGN_NONE |-> m_tdata[97:96] == AXIS_X)
        else $error("start inside box but entry axis is not x");

    a_sign_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[99:98] != 2'b10 && m_tdata[97:96] != 2'b11)
        else $error("invalid entry sign or axis code");

endmodule
